/* rtl/tmms_pkg.sv */
// Shared types, codes and reset constants of the mode sequencer.
package tmms_pkg;

   // Vehicle mode codes
   localparam logic [1:0] MODE_ROTOR     = 2'd0;
   localparam logic [1:0] MODE_TO_GROUND = 2'd1;
   localparam logic [1:0] MODE_GROUND    = 2'd2;
   localparam logic [1:0] MODE_TO_ROTOR  = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] CSR_GROUND_TARGET = 3'd0;
   localparam logic [2:0] CSR_ROTOR_TARGET  = 3'd1;
   localparam logic [2:0] CSR_GROUND_DRIVE  = 3'd2;
   localparam logic [2:0] CSR_ROTOR_DRIVE   = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT       = 3'd4;
   localparam logic [2:0] CSR_DEADBAND      = 3'd5;
   localparam logic [2:0] CSR_PUBLISH_THR   = 3'd6;

   // Configuration reset values
   localparam logic signed [15:0] GROUND_TARGET_RST = 16'sd6434;
   localparam logic signed [15:0] ROTOR_TARGET_RST  = 16'sd0;
   localparam logic signed [15:0] GROUND_DRIVE_RST  = 16'sd8192;
   localparam logic signed [15:0] ROTOR_DRIVE_RST   = 16'sd8192;
   localparam logic [31:0]        TIMEOUT_RST       = 32'd10000000;
   localparam logic [11:0]        DEADBAND_RST      = 12'd205;
   localparam logic [14:0]        PUBLISH_THR_RST   = 15'd164;

   // Full-scale drive in Q14
   localparam logic signed [15:0] DRIVE_FULL     = 16'sd16384;
   localparam logic signed [15:0] DRIVE_FULL_NEG = -16'sd16384;

   typedef struct packed {
      logic signed [15:0] ground_target_angle;
      logic signed [15:0] rotor_target_angle;
      logic signed [15:0] ground_drive_level;
      logic signed [15:0] rotor_drive_level;
      logic [31:0]        timeout_limit_us;
      logic [11:0]        angle_deadband;
      logic [14:0]        publish_threshold;
   } cfg_type;

   typedef struct packed {
      logic               ground_requested;
      logic               encoder_valid;
      logic signed [15:0] encoder_angle;
      logic [15:0]        elapsed_us;
   } item_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] held_angle;
      logic               timer_running;
      logic [31:0]        timer_count;
      logic signed [15:0] drive;
      logic signed [15:0] last_published;
      logic               rotor_weight;
   } state_type;

   typedef struct packed {
      logic [1:0]         vehicle_mode;
      logic               rotor_control_on;
      logic signed [15:0] drive_command;
      logic               publish_now;
      logic               timed_out;
   } result_type;

   // Clamp a drive level to full scale
   function automatic logic signed [15:0] sat_drive(input logic signed [15:0] v);
      logic signed [15:0] r;
      r = v;
      if (v > DRIVE_FULL) begin
         r = DRIVE_FULL;
      end else if (v < DRIVE_FULL_NEG) begin
         r = DRIVE_FULL_NEG;
      end
      return r;
   endfunction

endpackage

/* rtl/tmms_csr.sv */
// Configuration register file of the mode sequencer.
module tmms_csr
   import tmms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode one write beat; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GROUND_TARGET: cfg_in.ground_target_angle = csr_wdata[15:0];
            CSR_ROTOR_TARGET:  cfg_in.rotor_target_angle  = csr_wdata[15:0];
            CSR_GROUND_DRIVE:  cfg_in.ground_drive_level  = csr_wdata[15:0];
            CSR_ROTOR_DRIVE:   cfg_in.rotor_drive_level   = csr_wdata[15:0];
            CSR_TIMEOUT:       cfg_in.timeout_limit_us    = csr_wdata;
            CSR_DEADBAND:      cfg_in.angle_deadband      = csr_wdata[11:0];
            CSR_PUBLISH_THR:   cfg_in.publish_threshold   = csr_wdata[14:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ground_target_angle <= GROUND_TARGET_RST;
         cfg_ff.rotor_target_angle  <= ROTOR_TARGET_RST;
         cfg_ff.ground_drive_level  <= GROUND_DRIVE_RST;
         cfg_ff.rotor_drive_level   <= ROTOR_DRIVE_RST;
         cfg_ff.timeout_limit_us    <= TIMEOUT_RST;
         cfg_ff.angle_deadband      <= DEADBAND_RST;
         cfg_ff.publish_threshold   <= PUBLISH_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/tmms_step.sv */
// One control tick: mode request, transition timer, angle checks and publish test.
module tmms_step
   import tmms_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  state_cur,
   input  item_type   item,
   output state_type  state_nxt,
   output result_type result
);

   state_type          st;
   logic               timeout_hit;
   logic               publish;
   logic [32:0]        timer_sum;
   logic signed [17:0] held_ext;
   logic signed [17:0] ground_bound;
   logic signed [17:0] rotor_bound;
   logic signed [16:0] pub_diff;
   logic [16:0]        pub_mag;

   // Angle limits with the deadband applied
   assign ground_bound = 18'(cfg.ground_target_angle) - $signed({6'd0, cfg.angle_deadband});
   assign rotor_bound  = 18'(cfg.rotor_target_angle) + $signed({6'd0, cfg.angle_deadband});
   assign timer_sum    = {1'b0, state_cur.timer_count} + {17'd0, item.elapsed_us};

   always_comb begin
      st          = state_cur;
      timeout_hit = 1'b0;
      held_ext    = 18'(state_cur.held_angle);

      // Apply the mode request
      if (!item.ground_requested) begin
         if (st.mode == MODE_ROTOR) begin
            st.rotor_weight = 1'b1;
         end else begin
            st.mode = MODE_TO_ROTOR;
         end
      end else begin
         if (st.mode == MODE_GROUND) begin
            st.rotor_weight = 1'b0;
         end else begin
            st.mode = MODE_TO_GROUND;
         end
      end

      // Run the transition: timer, encoder capture, timeout and angle checks
      if (st.mode == MODE_TO_GROUND || st.mode == MODE_TO_ROTOR) begin
         if (!st.timer_running) begin
            st.timer_running = 1'b1;
            st.timer_count   = '0;
         end else begin
            st.timer_count = timer_sum[32] ? '1 : timer_sum[31:0];
         end
         if (item.encoder_valid) begin
            st.held_angle = item.encoder_angle;
         end
         held_ext = 18'(st.held_angle);

         if (st.timer_count > cfg.timeout_limit_us) begin
            st.mode          = MODE_ROTOR;
            st.rotor_weight  = 1'b1;
            st.timer_running = 1'b0;
            st.timer_count   = '0;
            st.drive         = '0;
            timeout_hit      = 1'b1;
         end else if (st.mode == MODE_TO_GROUND) begin
            st.rotor_weight = 1'b1;
            if (held_ext > ground_bound) begin
               st.drive = sat_drive(cfg.ground_drive_level);
            end else begin
               st.mode          = MODE_GROUND;
               st.rotor_weight  = 1'b0;
               st.drive         = '0;
               st.timer_running = 1'b0;
               st.timer_count   = '0;
            end
         end else begin
            st.rotor_weight = 1'b1;
            if (held_ext < rotor_bound) begin
               st.drive = 16'(-sat_drive(cfg.rotor_drive_level));
            end else begin
               st.mode          = MODE_ROTOR;
               st.drive         = '0;
               st.timer_running = 1'b0;
               st.timer_count   = '0;
            end
         end
      end
   end

   // Publish when the command moved past the threshold
   always_comb begin
      pub_diff = 17'(st.drive) - 17'(state_cur.last_published);
      pub_mag  = pub_diff[16] ? 17'(-pub_diff) : 17'(pub_diff);
      publish  = pub_mag > {2'd0, cfg.publish_threshold};

      state_nxt = st;
      if (publish) begin
         state_nxt.last_published = st.drive;
      end

      result.vehicle_mode     = st.mode;
      result.rotor_control_on = st.rotor_weight;
      result.drive_command    = st.drive;
      result.publish_now      = publish;
      result.timed_out        = timeout_hit;
   end

endmodule

/* rtl/transform_mechanism_mode_sequencer_unit.sv */
// Top level of the transforming mechanism mode sequencer.
// Each request beat is one control tick; each tick gives exactly one response beat
// with the mode, rotor control weight, drive command and publish/timeout flags.
// The block takes one tick per clock cycle while the response is not stalled: a tick
// is registered on accept, passes once through the mode/timer/angle compare logic and
// lands in the response register, which drives the response channel. The
// sequencer state advances only when a tick moves into the response register, so a
// stalled response holds the input stage and back-pressures the request side.
// Configuration writes are taken in any cycle (csr_ready is always high) and must
// only be issued while no tick is in flight.
module transform_mechanism_mode_sequencer_unit
   import tmms_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_ground_requested,
   input  logic               req_encoder_valid,
   input  logic signed [15:0] req_encoder_angle,
   input  logic [15:0]        req_elapsed_us,
   // Response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_vehicle_mode,
   output logic               rsp_rotor_control_on,
   output logic signed [15:0] rsp_drive_command,
   output logic               rsp_publish_now,
   output logic               rsp_timed_out,
   // Configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       s1_valid_ff;
   logic       rsp_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   logic       advance;
   logic       req_take;

   assign csr_ready = 1'b1;

   tmms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tmms_step u_step (
      .cfg       (cfg),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // Move a tick to the response register when that register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign item_in.ground_requested = req_ground_requested;
   assign item_in.encoder_valid    = req_encoder_valid;
   assign item_in.encoder_angle    = req_encoder_angle;
   assign item_in.elapsed_us       = req_elapsed_us;

   // Stage occupancy and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_ROTOR, held_angle: '0, timer_running: 1'b0,
                           timer_count: '0, drive: '0, last_published: '0,
                           rotor_weight: 1'b0};
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_vehicle_mode     = result_ff.vehicle_mode;
   assign rsp_rotor_control_on = result_ff.rotor_control_on;
   assign rsp_drive_command    = result_ff.drive_command;
   assign rsp_publish_now      = result_ff.publish_now;
   assign rsp_timed_out        = result_ff.timed_out;

   // Timeout always lands in rotor mode with the drive zeroed
   a_timeout_rotor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.timed_out |->
         result_ff.vehicle_mode == MODE_ROTOR && result_ff.drive_command == 16'sd0)
      else $error("timeout beat not in rotor mode with zero drive");

   // Rotor control is off exactly in ground mode
   a_weight_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         result_ff.rotor_control_on == (result_ff.vehicle_mode != MODE_GROUND))
      else $error("rotor weight disagrees with mode");

   // Timer only runs during a transition
   a_timer_transition: assert property (@(posedge clock) disable iff (reset)
      state_ff.timer_running |->
         state_ff.mode == MODE_TO_GROUND || state_ff.mode == MODE_TO_ROTOR)
      else $error("transition timer running outside a transition");

   // Drive stays inside full scale
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.drive <= DRIVE_FULL && state_ff.drive >= DRIVE_FULL_NEG)
      else $error("drive command out of range");

   // A held tick blocked by a stalled response keeps the state unchanged
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("sequencer state moved without a tick");

endmodule
